### design/cpl_pkg.sv
// Package for the chassis power limiter: payload structs, constants and
// the drive-mode multiplier function. No dependencies.
package cpl_pkg;

  localparam int NumMotorsDef = 4;
  localparam int MaxMotors    = 4;
  localparam int QBits        = 16;
  localparam int PowW         = 23;
  localparam int LimW         = 16;
  localparam int NumStages    = 23;
  localparam logic [21:0] KpQ40   = 22'd3079732;
  localparam logic [20:0] Recip10 = 21'd1677722;
  localparam logic [17:0] Unity   = 18'd65536;
  localparam logic [15:0] CurSat  = 16'd16384;
  localparam logic [18:0] PwrMax  = 19'd524287;
  localparam logic [14:0] BoostMv = 15'd14000;

  localparam logic [1:0] RegThresh = 2'd0;
  localparam logic [1:0] RegLevel  = 2'd1;
  localparam logic [1:0] RegPlim   = 2'd2;

  localparam logic [1:0] ModeSpin   = 2'd1;
  localparam logic [1:0] ModeFollow = 2'd2;

  typedef struct packed {
    logic signed [15:0] current_0;
    logic signed [15:0] current_1;
    logic signed [15:0] current_2;
    logic signed [15:0] current_3;
    logic signed [15:0] speed_0;
    logic signed [15:0] speed_1;
    logic signed [15:0] speed_2;
    logic signed [15:0] speed_3;
    logic [8:0]         buffer_energy;
    logic [14:0]        cap_millivolts;
    logic [1:0]         drive_mode;
    logic [2:0]         request_flags;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_current_0;
    logic signed [15:0] out_current_1;
    logic signed [15:0] out_current_2;
    logic signed [15:0] out_current_3;
    logic               power_route;
    logic               was_scaled;
    logic [17:0]        scale_factor;
    logic [18:0]        power_estimate;
  } out_t;

  typedef struct packed {
    logic [MaxMotors-1:0][15:0] mag;
    logic [MaxMotors-1:0]       neg;
    logic [LimW-1:0]            limit_q8;
    logic                       route;
    logic [4:0]                 mult;
    logic [PowW-1:0]            power;
    logic                       scaled;
  } side_t;

  function automatic logic [4:0] mode_mult(input logic [1:0] mode, input logic still,
                                           input logic [7:0] p);
    logic [4:0] m;
    m = 5'd10;
    if (mode == ModeSpin && still) begin
      if (p < 8'd90 && p > 8'd65) m = 5'd12;
      else if (p > 8'd90) m = 5'd15;
    end else if (mode == ModeSpin) begin
      if (p < 8'd90 && p > 8'd58) m = 5'd13;
      else if (p > 8'd90) m = 5'd17;
    end else if (mode == ModeFollow) begin
      if (p < 8'd90 && p > 8'd58) m = 5'd12;
      else if (p > 8'd90) m = 5'd15;
    end
    return m;
  endfunction

endpackage

### design/cpl_power_lane.sv
// One motor lane of the power estimate: magnitude of current and |I*rpm|.
// Uses cpl_pkg nothing; plain registered multiply.
module cpl_power_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] current,
  input  logic signed [15:0] speed,
  output logic [15:0]        mag,
  output logic               neg,
  output logic [30:0]        prod
);

  logic [15:0] cmag;
  logic [15:0] smag;

  assign cmag = current[15] ? 16'(-current) : 16'(current);
  assign smag = speed[15] ? 16'(-speed) : 16'(speed);

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= cmag;
      neg  <= current[15];
      prod <= 31'(32'(cmag) * 32'(smag));
    end
  end

endmodule

### design/cpl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses cpl_pkg for widths.
module cpl_div (
  input  logic                        clk,
  input  logic [cpl_pkg::QBits-1:0]   en,
  input  logic [cpl_pkg::PowW-1:0]    rem_in,
  input  logic [cpl_pkg::PowW-1:0]    den_in,
  output logic [cpl_pkg::QBits-1:0]   quot
);

  localparam int W = cpl_pkg::PowW;
  localparam int Q = cpl_pkg::QBits;

  logic [W-1:0] r [Q];
  logic [W-1:0] d [Q];
  logic [Q-1:0] q [Q];

  genvar j;
  generate
    for (j = 0; j < Q; j++) begin : g_st
      logic [W-1:0] rp;
      logic [W-1:0] dp;
      logic [Q-1:0] qp;
      logic [W:0]   sh;
      logic         ge;
      if (j == 0) begin : g_first
        assign rp = rem_in;
        assign dp = den_in;
        assign qp = '0;
      end else begin : g_next
        assign rp = r[j-1];
        assign dp = d[j-1];
        assign qp = q[j-1];
      end
      assign sh = {rp, 1'b0};
      assign ge = sh >= {1'b0, dp};
      always_ff @(posedge clk) begin
        if (en[j]) begin
          r[j] <= ge ? W'(sh - {1'b0, dp}) : W'(sh);
          d[j] <= dp;
          q[j] <= {qp[Q-2:0], ge};
        end
      end
    end
  endgenerate

  assign quot = q[Q-1];

endmodule

### design/cpl_scale_lane.sv
// One motor lane of the output: |I| times factor, truncated, saturated, signed.
// Uses cpl_pkg for the saturation bound.
module cpl_scale_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        mag,
  input  logic               neg,
  input  logic [17:0]        factor,
  output logic signed [15:0] out_current
);

  logic [33:0] prod;
  logic [17:0] mg;
  logic [15:0] sat;

  assign prod = 34'(mag) * 34'(factor);
  assign mg   = prod[33:16];
  assign sat  = (mg > 18'(cpl_pkg::CurSat)) ? cpl_pkg::CurSat : mg[15:0];

  always_ff @(posedge clk) begin
    if (en) out_current <= neg ? signed'(16'(-sat)) : signed'(sat);
  end

endmodule

### design/chassis_power_limiter_top.sv
// Top level of the chassis power limiter: APB registers, lane pipeline,
// divider and output stage. Uses cpl_pkg, cpl_power_lane, cpl_div, cpl_scale_lane.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid / req_ready | cpl_pkg::in_t
//   rsp      | out       | rsp_valid / rsp_ready | cpl_pkg::out_t
//   apb      | in        | psel / penable        | paddr, pwdata, prdata
//
// One request per cycle unless stalled; the pipeline is the 16-stage divider plus
// the estimate, multiplier and output stages. Each stage advances when its next
// stage is empty or advancing, so bubbles close up under an output stall.
// Synchronous reset clears stage valids and loads register defaults.
module chassis_power_limiter_top #(
  parameter int NUM_MOTORS = cpl_pkg::NumMotorsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cpl_pkg::in_t   req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cpl_pkg::out_t  rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int N  = cpl_pkg::NumStages;
  localparam int M  = cpl_pkg::MaxMotors;
  localparam int DB = 4;
  localparam int DE = DB + cpl_pkg::QBits - 1;

  logic [7:0] buffer_threshold;
  logic [3:0] power_tier;
  logic [7:0] referee_power_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_threshold    <= 8'd20;
      power_tier          <= 4'd1;
      referee_power_limit <= 8'd50;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cpl_pkg::RegThresh: buffer_threshold    <= pwdata[7:0];
        cpl_pkg::RegLevel:  power_tier          <= pwdata[3:0];
        cpl_pkg::RegPlim:   referee_power_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cpl_pkg::RegThresh: prdata = {24'd0, buffer_threshold};
      cpl_pkg::RegLevel:  prdata = {28'd0, power_tier};
      cpl_pkg::RegPlim:   prdata = {24'd0, referee_power_limit};
      default:            prdata = '0;
    endcase
  end

  // stage control
  logic [N-1:0] v;
  logic [N:0]   en;

  always_comb begin
    en[N] = rsp_ready;
    for (int k = N - 1; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  assign req_ready = en[0];
  assign rsp_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: lanes and limit selection
  logic signed [M-1:0][15:0] cur_in;
  logic signed [M-1:0][15:0] spd_in;
  logic [M-1:0][15:0] mag1;
  logic [M-1:0]       neg1;
  logic [M-1:0][30:0] prod1;

  assign cur_in = {req.current_3, req.current_2, req.current_1, req.current_0};
  assign spd_in = {req.speed_3, req.speed_2, req.speed_1, req.speed_0};

  genvar i;
  generate
    for (i = 0; i < M; i++) begin : g_plane
      if (i < NUM_MOTORS) begin : g_on
        cpl_power_lane u_lane (
          .clk     (clk),
          .en      (en[0]),
          .current (cur_in[i]),
          .speed   (spd_in[i]),
          .mag     (mag1[i]),
          .neg     (neg1[i]),
          .prod    (prod1[i])
        );
      end else begin : g_off
        assign mag1[i]  = '0;
        assign neg1[i]  = 1'b0;
        assign prod1[i] = '0;
      end
    end
  endgenerate

  logic [7:0]  limit_w;
  logic        boost;
  logic [7:0]  plim;
  logic [15:0] lim1;
  logic        route1;
  logic [4:0]  mult1;

  always_comb begin
    if (9'(buffer_threshold) > req.buffer_energy) limit_w = req.buffer_energy[7:0];
    else if (power_tier == 4'd2) limit_w = 8'd80;
    else if (power_tier == 4'd3) limit_w = 8'd100;
    else limit_w = 8'd60;
    boost = req.request_flags[0] && req.request_flags[1] &&
            (req.cap_millivolts > cpl_pkg::BoostMv);
    if (boost) limit_w = 8'd150;
    plim = (referee_power_limit == 8'd0) ? 8'd50 : referee_power_limit;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lim1   <= {limit_w, 8'd0};
      route1 <= boost;
      mult1  <= cpl_pkg::mode_mult(req.drive_mode, req.request_flags[2], plim);
    end
  end

  // stage 2: sum of lane products
  cpl_pkg::side_t sb2, sb3, sb4;
  cpl_pkg::side_t sb2_next, sb4_next;
  logic [32:0] sum2;

  always_comb begin
    sb2_next          = '0;
    sb2_next.mag      = mag1;
    sb2_next.neg      = neg1;
    sb2_next.limit_q8 = lim1;
    sb2_next.route    = route1;
    sb2_next.mult     = mult1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sb2  <= sb2_next;
      sum2 <= 33'(prod1[0]) + 33'(prod1[1]) + 33'(prod1[2]) + 33'(prod1[3]);
    end
  end

  // stage 3: split multiply by KP
  logic [38:0] hi3;
  logic [37:0] lo3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sb3 <= sb2;
      hi3 <= 39'(sum2[32:16]) * 39'(cpl_pkg::KpQ40);
      lo3 <= 38'(sum2[15:0]) * 38'(cpl_pkg::KpQ40);
    end
  end

  // stage 4: round, compare with limit
  logic [55:0] tot;
  logic [22:0] pow4;

  assign tot  = {1'b0, hi3, 16'd0} + 56'(lo3) + 56'h0000_0080_0000_00;
  assign pow4 = tot[54:32];

  always_comb begin
    sb4_next        = sb3;
    sb4_next.power  = pow4;
    sb4_next.scaled = pow4 > 23'(sb3.limit_q8);
  end

  always_ff @(posedge clk) begin
    if (en[3]) sb4 <= sb4_next;
  end

  // divider stages carry the sideband alongside
  logic [cpl_pkg::QBits-1:0] quot;
  cpl_pkg::side_t sbd [DB:DE];

  cpl_div u_div (
    .clk    (clk),
    .en     (en[DE:DB]),
    .rem_in (23'(sb4.limit_q8)),
    .den_in (sb4.power),
    .quot   (quot)
  );

  genvar s;
  generate
    for (s = DB; s <= DE; s++) begin : g_sb
      always_ff @(posedge clk) begin
        if (en[s]) sbd[s] <= (s == DB) ? sb4 : sbd[(s == DB) ? DB : s-1];
      end
    end
  endgenerate

  // multiplier stage and divide by ten
  cpl_pkg::side_t sbm, sbf, sbo;
  logic [20:0] xm;
  logic [41:0] xr;
  logic [17:0] fac;

  always_ff @(posedge clk) begin
    if (en[DE+1]) begin
      sbm <= sbd[DE];
      xm  <= 21'(quot) * 21'(sbd[DE].mult);
    end
  end

  assign xr = 42'(xm) * 42'(cpl_pkg::Recip10);

  always_ff @(posedge clk) begin
    if (en[DE+2]) begin
      sbf <= sbm;
      fac <= sbm.scaled ? xr[41:24] : cpl_pkg::Unity;
    end
  end

  // output stage
  logic signed [M-1:0][15:0] oc;

  generate
    for (i = 0; i < M; i++) begin : g_slane
      if (i < NUM_MOTORS) begin : g_on
        cpl_scale_lane u_lane (
          .clk         (clk),
          .en          (en[N-1]),
          .mag         (sbf.mag[i]),
          .neg         (sbf.neg[i]),
          .factor      (fac),
          .out_current (oc[i])
        );
      end else begin : g_off
        assign oc[i] = '0;
      end
    end
  endgenerate

  logic [17:0] fac_o;

  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      sbo   <= sbf;
      fac_o <= fac;
    end
  end

  always_comb begin
    rsp.out_current_0  = oc[0];
    rsp.out_current_1  = oc[1];
    rsp.out_current_2  = oc[2];
    rsp.out_current_3  = oc[3];
    rsp.power_route    = sbo.route;
    rsp.was_scaled     = sbo.scaled;
    rsp.scale_factor   = fac_o;
    rsp.power_estimate = (sbo.power > 23'(cpl_pkg::PwrMax)) ? cpl_pkg::PwrMax
                                                            : sbo.power[18:0];
  end

  a_unity : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.was_scaled |-> rsp.scale_factor == cpl_pkg::Unity)
    else $error("unscaled result without unity factor");

  a_scaled_range : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.was_scaled |-> rsp.scale_factor <= 18'd111410)
    else $error("scale factor out of range");

  a_sat : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.out_current_0 <= 16'sd16384 && rsp.out_current_0 >= -16'sd16384 &&
                  rsp.out_current_3 <= 16'sd16384 && rsp.out_current_3 >= -16'sd16384)
    else $error("output current not saturated");

endmodule
